FILE: rtl/core/dltm_pkg.sv
// ----------------------------------------------------------------------------
// dltm_pkg
// Shared types and constants for the delta-list timer manager.
// ----------------------------------------------------------------------------
package dltm_pkg;

  localparam int TableDepthDef = 16;
  localparam int DelayBitsDef  = 16;
  localparam int MaxResults    = 16;
  localparam int DelayInBits   = 16;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    EV_SET_OK   = 2'd0,
    EV_SET_FULL = 2'd1,
    EV_EXPIRED  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic                   command;
    logic [7:0]             timer_id;
    logic [DelayInBits-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] event_id;
    logic       last_event;
  } out_item_t;

endpackage

FILE: rtl/core/dltm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dltm_cmd_fifo
// Two-entry command queue between the input channel and the engine.
// ----------------------------------------------------------------------------
module dltm_cmd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dltm_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output dltm_pkg::in_item_t q_data
);

  dltm_pkg::in_item_t mem_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

endmodule

FILE: rtl/core/dltm_engine.sv
// ----------------------------------------------------------------------------
// dltm_engine
// Delta-list table and sequencer: insertion walk, tick and expiry, result reg.
// ----------------------------------------------------------------------------
module dltm_engine #(
  parameter int TABLE_DEPTH = dltm_pkg::TableDepthDef,
  parameter int DELAY_BITS  = dltm_pkg::DelayBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  dltm_pkg::in_item_t  q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dltm_pkg::out_item_t out_data
);

  localparam int DW = DELAY_BITS + 2;
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(dltm_pkg::MaxResults);

  typedef enum logic [1:0] {S_IDLE, S_SET, S_TICK, S_EXP} state_t;

  state_t               state_r;
  logic [7:0]           ids_r    [TABLE_DEPTH];
  logic signed [DW-1:0] deltas_r [TABLE_DEPTH];
  logic [CW-1:0]        count_r;
  logic [PW-1:0]        pos_r;
  logic [NW-1:0]        n_r;
  logic signed [DW-1:0] remain_r;
  logic [7:0]           id_r;
  logic                 out_valid_r;
  dltm_pkg::out_item_t  out_data_r;

  logic                 can_emit;
  logic [DELAY_BITS-1:0] dl;
  logic signed [DW-1:0] dpos;
  logic                 full, walk_more, exp_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_emit  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign dpos      = deltas_r[pos_r];
  assign walk_more = (CW'(pos_r) < count_r) && (dpos <= remain_r);
  assign exp_last  = (n_r == NW'(dltm_pkg::MaxResults - 1)) || (count_r == CW'(1)) ||
                     (deltas_r[1] > DW'(0));

  always_comb begin
    for (int b = 0; b < DELAY_BITS; b++) begin
      dl[b] = (b < dltm_pkg::DelayInBits) ? q_data.delay_ticks[b] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            id_r     <= q_data.timer_id;
            remain_r <= DW'({2'b00, dl});
            pos_r    <= '0;
            n_r      <= '0;
            state_r  <= (q_data.command == dltm_pkg::CMD_TICK) ? S_TICK : S_SET;
          end
        end
        S_SET: begin
          if (full) begin
            if (can_emit) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{event_kind: dltm_pkg::EV_SET_FULL, event_id: id_r,
                               last_event: 1'b1};
              state_r     <= S_IDLE;
            end
          end else if (walk_more) begin
            remain_r <= remain_r - dpos;
            pos_r    <= pos_r + PW'(1);
          end else if (can_emit) begin
            if (pos_r == '0) begin
              ids_r[0]    <= id_r;
              deltas_r[0] <= remain_r;
            end
            for (int i = 1; i < TABLE_DEPTH; i++) begin
              if (i == int'(pos_r)) begin
                ids_r[i]    <= id_r;
                deltas_r[i] <= remain_r;
              end else if (i > int'(pos_r)) begin
                ids_r[i]    <= ids_r[i-1];
                deltas_r[i] <= (i == int'(pos_r) + 1) ? deltas_r[i-1] - remain_r
                                                      : deltas_r[i-1];
              end
            end
            count_r     <= count_r + CW'(1);
            out_valid_r <= 1'b1;
            out_data_r  <= '{event_kind: dltm_pkg::EV_SET_OK, event_id: id_r,
                             last_event: 1'b1};
            state_r     <= S_IDLE;
          end
        end
        S_TICK: begin
          if (count_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            deltas_r[0] <= deltas_r[0] - DW'(1);
            state_r     <= S_EXP;
          end
        end
        S_EXP: begin
          if (count_r == '0 || deltas_r[0] > DW'(0)) begin
            state_r <= S_IDLE;
          end else if (can_emit) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{event_kind: dltm_pkg::EV_EXPIRED, event_id: ids_r[0],
                             last_event: exp_last};
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
              ids_r[i]    <= ids_r[i+1];
              deltas_r[i] <= deltas_r[i+1];
            end
            count_r <= count_r - CW'(1);
            n_r     <= n_r + NW'(1);
            if (exp_last) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/delta_list_timer_manager.sv
// ----------------------------------------------------------------------------
// delta_list_timer_manager
// Delta-list software timer queue with set and tick commands.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries set and tick commands into
// a two-entry command queue; the engine takes one command at a time.
// Output channel out_valid/out_stall/out_data carries result transactions
// through one output register.
// A set walks the table one entry per cycle, then writes one result.
// A tick on an empty table gives no result; otherwise it emits one expiry
// result per due timer (up to 16 per tick), and none when nothing is due.
// A set into a full table returns a reject result.
// Throughput is bounded by the single sequencer walking the table.
// Reset empties the table and the queue; no clearing pass is needed.
// While the receiver stalls, the engine holds its next result and the input
// queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module delta_list_timer_manager #(
  parameter int TABLE_DEPTH = dltm_pkg::TableDepthDef,
  parameter int DELAY_BITS  = dltm_pkg::DelayBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dltm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dltm_pkg::out_item_t out_data
);

  logic               q_valid, q_pop;
  dltm_pkg::in_item_t q_data;

  dltm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  dltm_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DELAY_BITS  (DELAY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
